// ===== sv/rgb_to_ycbcr_440_subsampler_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_440_subsampler assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YCBCR_440_SUBSAMPLER_ASSERT_SVH
`define RGB_TO_YCBCR_440_SUBSAMPLER_ASSERT_SVH

// boolean condition that holds at every edge
`define YCC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next
`define YCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ycc_pkg.sv =====
// ----------------------------------------------------------------------------
// ycc_pkg
// shared constants, types and helpers of the rgb to ycbcr 4:4:0 subsampler
// ----------------------------------------------------------------------------
package ycc_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int MAX_ROWS  = 4096;
  localparam int ROW_W     = $clog2(MAX_ROWS);

  localparam int FRAC_BITS = 8;
  localparam int COEF_BITS = 16;
  localparam int LUMA_SH   = COEF_BITS - FRAC_BITS;
  localparam int CHROMA_SH = 2 * COEF_BITS - FRAC_BITS;

  localparam int PIX_W    = 8;
  localparam int LUMA_W   = 16;
  localparam int CHROMA_W = 17;
  localparam int K_W      = COEF_BITS + 2;
  localparam int Y16_W    = PIX_W + COEF_BITS + 1;
  localparam int D_W      = PIX_W + COEF_BITS + 2;
  localparam int P_W      = D_W + COEF_BITS + 1;

  // configuration register map
  localparam int LW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LUMA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // coefficients with COEF_BITS fraction
  localparam logic signed [K_W-1:0] K_R    = K_W'(19595);
  localparam logic signed [K_W-1:0] K_G    = K_W'(38470);
  localparam logic signed [K_W-1:0] K_B    = K_W'(7471);
  localparam logic signed [K_W-1:0] K_CB   = K_W'(37028);
  localparam logic signed [K_W-1:0] K_CR   = K_W'(46727);
  localparam logic signed [K_W-1:0] K_DB_B = K_W'((1 << COEF_BITS) - 7471);
  localparam logic signed [K_W-1:0] K_DR_R = K_W'((1 << COEF_BITS) - 19595);

  localparam logic signed [Y16_W-1:0] LUMA_HI = Y16_W'((1 << (LUMA_W - 1)) - 1);
  localparam logic signed [Y16_W-1:0] LUMA_LO = Y16_W'(-(1 << (LUMA_W - 1)));
  localparam logic signed [P_W-1:0]   CHR_HI  = P_W'((1 << (CHROMA_W - 1)) - 1);
  localparam logic signed [P_W-1:0]   CHR_LO  = P_W'(-(1 << (CHROMA_W - 1)));

  // raster position and per-pixel control, travels with the pixel
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              odd;
    logic              last_even;
    logic              emit;
    logic              keep_luma;
  } pos_t;

  typedef struct packed {
    logic signed [CHROMA_W-1:0] cb;
    logic signed [CHROMA_W-1:0] cr;
  } chroma_t;

  function automatic logic signed [LUMA_W-1:0] sat_luma(input logic signed [Y16_W-1:0] v);
    if (v > LUMA_HI) return LUMA_HI[LUMA_W-1:0];
    if (v < LUMA_LO) return LUMA_LO[LUMA_W-1:0];
    return v[LUMA_W-1:0];
  endfunction

  function automatic logic signed [CHROMA_W-1:0] sat_chroma(input logic signed [P_W-1:0] v);
    if (v > CHR_HI) return CHR_HI[CHROMA_W-1:0];
    if (v < CHR_LO) return CHR_LO[CHROMA_W-1:0];
    return v[CHROMA_W-1:0];
  endfunction

endpackage

// ===== sv/rgb_to_ycbcr_440_subsampler.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_440_subsampler
// rgb to level-shifted ycbcr with 4:4:0 chroma averaging over row pairs
// ----------------------------------------------------------------------------
// an input transfer reaches out_valid through the stage registers and the output register
// throughput: one pixel per cycle unless out_stall backs up the pipeline, set by the
//   single line buffer access (read on odd rows, write on even rows) made by each pixel
// reset: clears counters, pipeline valids and configuration to defaults;
//   the line buffer is not cleared and holds data only once an even row is in
// ----------------------------------------------------------------------------
module rgb_to_ycbcr_440_subsampler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ycc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ycc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ycc_pkg::PIX_W-1:0]            red,
  input  logic [ycc_pkg::PIX_W-1:0]            green,
  input  logic [ycc_pkg::PIX_W-1:0]            blue,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ycc_pkg::LUMA_W-1:0]    luma,
  output logic signed [ycc_pkg::CHROMA_W-1:0]  blue_diff,
  output logic signed [ycc_pkg::CHROMA_W-1:0]  red_diff,
  output logic                                 chroma_valid
);
  import ycc_pkg::*;

  `include "rgb_to_ycbcr_440_subsampler_assert.svh"

  pos_t pos;
  logic acc;

  // stage registers
  logic v1, v2, v3, v4;
  pos_t p1, p2, p3, p4;
  logic signed [PIX_W-1:0]    r1, g1, b1;
  logic signed [Y16_W-1:0]    y16_2;
  logic signed [D_W-1:0]      db2, dr2;
  logic signed [LUMA_W-1:0]   y3, y4;
  logic signed [P_W-1:0]      pb3, pr3;
  chroma_t                    c4;
  chroma_t                    stored;

  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic adv3, adv4;
  logic ram_we, ram_re;

  logic signed [Y16_W-1:0]    y16_c, y_rnd;
  logic signed [D_W-1:0]      db_c, dr_c;
  logic signed [P_W-1:0]      pb_rnd, pr_rnd;
  chroma_t                    c3;
  logic signed [CHROMA_W:0]   sum_cb, sum_cr;

  ycc_raster u_raster (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (acc),
    .pos       (pos)
  );

  // elastic pipeline: a stage loads when it is empty or its content moves on
  assign rdy_o    = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy_o;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign adv3     = v3 && rdy4;
  assign adv4     = v4 && rdy_o;
  assign in_stall = !rdy1;
  assign acc      = in_valid && rdy1;

  // stage 1 -> 2: luma and the two color differences at COEF_BITS fraction
  assign y16_c = Y16_W'(K_R * r1) + Y16_W'(K_G * g1) + Y16_W'(K_B * b1);
  assign db_c  = D_W'(K_DB_B * b1) - D_W'(K_R * r1) - D_W'(K_G * g1);
  assign dr_c  = D_W'(K_DR_R * r1) - D_W'(K_G * g1) - D_W'(K_B * b1);

  // stage 2 -> 3: luma rounding, chroma scaling
  assign y_rnd = (y16_2 + Y16_W'(1 << (LUMA_SH - 1))) >>> LUMA_SH;

  // stage 3 -> 4: chroma rounding, line buffer access
  assign pb_rnd = (pb3 + P_W'(64'(1) << (CHROMA_SH - 1))) >>> CHROMA_SH;
  assign pr_rnd = (pr3 + P_W'(64'(1) << (CHROMA_SH - 1))) >>> CHROMA_SH;
  assign c3.cb  = sat_chroma(pb_rnd);
  assign c3.cr  = sat_chroma(pr_rnd);
  assign ram_we = adv3 && !p3.odd;
  assign ram_re = adv3 && p3.odd;

  ycc_line_ram u_line (
    .clk   (clk),
    .wr    (ram_we),
    .rd    (ram_re),
    .addr  (p3.addr),
    .wdata (c3),
    .rdata (stored)
  );

  // stage 4 -> out: row pair average, ties toward +infinity
  assign sum_cb = (CHROMA_W+1)'(stored.cb) + (CHROMA_W+1)'(c4.cb) + (CHROMA_W+1)'(1);
  assign sum_cr = (CHROMA_W+1)'(stored.cr) + (CHROMA_W+1)'(c4.cr) + (CHROMA_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy_o) out_valid <= v4 && p4.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      // level shift by flipping the msb
      r1 <= {~red[PIX_W-1], red[PIX_W-2:0]};
      g1 <= {~green[PIX_W-1], green[PIX_W-2:0]};
      b1 <= {~blue[PIX_W-1], blue[PIX_W-2:0]};
      p1 <= pos;
    end
    if (rdy2 && v1) begin
      y16_2 <= y16_c;
      db2   <= db_c;
      dr2   <= dr_c;
      p2    <= p1;
    end
    if (rdy3 && v2) begin
      y3  <= sat_luma(y_rnd);
      pb3 <= P_W'(db2 * K_CB);
      pr3 <= P_W'(dr2 * K_CR);
      p3  <= p2;
    end
    if (adv3) begin
      y4 <= y3;
      c4 <= c3;
      p4 <= p3;
    end
    if (adv4 && p4.emit) begin
      luma         <= p4.keep_luma ? y4 : '0;
      chroma_valid <= p4.odd || p4.last_even;
      if (p4.odd) begin
        blue_diff <= sum_cb[CHROMA_W:1];
        red_diff  <= sum_cr[CHROMA_W:1];
      end else if (p4.last_even) begin
        blue_diff <= c4.cb;
        red_diff  <= c4.cr;
      end else begin
        blue_diff <= '0;
        red_diff  <= '0;
      end
    end
  end

  `YCC_ASSERT(a_stall_only_full, !in_stall || v1, "input stalled with an empty first stage")
  `YCC_ASSERT(a_ram_one_access, !(ram_we && ram_re), "line buffer read and write in one cycle")
  `YCC_ASSERT(a_chroma_zero, !out_valid || chroma_valid || (blue_diff == '0 && red_diff == '0),
              "chroma fields not zero without chroma")
  `YCC_ASSERT_NEXT(a_emit_reaches_out, adv4 && p4.emit, out_valid, "emitted pixel lost")

endmodule

// ===== sv/ycc_raster.sv =====
// ----------------------------------------------------------------------------
// ycc_raster
// configuration registers and column/row counters of the pixel stream
// ----------------------------------------------------------------------------
module ycc_raster (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ycc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ycc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           step,
  output ycc_pkg::pos_t                  pos
);
  import ycc_pkg::*;

  localparam int WC_W = (LW_W > ADDR_W + 1) ? LW_W : ADDR_W + 1;
  localparam int HC_W = (FH_W > ROW_W + 1) ? FH_W : ROW_W + 1;

  logic              keep_luma;
  logic [LW_W-1:0]   line_width;
  logic [FH_W-1:0]   frame_height;
  logic [ADDR_W-1:0] col;
  logic [ROW_W-1:0]  row;

  logic [LW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic [WC_W-1:0] col_inc;
  logic [HC_W-1:0] row_inc;
  logic            row_end;
  logic            frame_end;
  logic            last_row;
  logic            chroma_out;

  always_comb begin
    w_eff = line_width;
    if (line_width == '0) w_eff = LW_W'(1);
    else if (line_width > LW_W'(MAX_WIDTH)) w_eff = LW_W'(MAX_WIDTH);
    h_eff = frame_height;
    if (frame_height == '0) h_eff = FH_W'(1);
    else if (frame_height > FH_W'(MAX_ROWS)) h_eff = FH_W'(MAX_ROWS);
  end

  assign col_inc    = WC_W'(col) + WC_W'(1);
  assign row_inc    = HC_W'(row) + HC_W'(1);
  assign row_end    = col_inc >= WC_W'(w_eff);
  assign frame_end  = row_inc >= HC_W'(h_eff);
  assign last_row   = row_inc == HC_W'(h_eff);
  assign chroma_out = row[0] || last_row;

  assign pos.addr      = col;
  assign pos.odd       = row[0];
  assign pos.last_even = !row[0] && last_row;
  assign pos.emit      = chroma_out || keep_luma;
  assign pos.keep_luma = keep_luma;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_luma    <= 1'b1;
      line_width   <= LW_W'(MAX_WIDTH);
      frame_height <= FH_W'(MAX_ROWS);
      col          <= '0;
      row          <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_KEEP_LUMA:    keep_luma    <= cfg_data[0];
          CFG_LINE_WIDTH:   line_width   <= cfg_data[LW_W-1:0];
          CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (step) begin
        if (row_end) begin
          col <= '0;
          if (frame_end) row <= '0;
          else row <= row_inc[ROW_W-1:0];
        end else begin
          col <= col_inc[ADDR_W-1:0];
        end
      end
    end
  end

endmodule

// ===== sv/ycc_line_ram.sv =====
// ----------------------------------------------------------------------------
// ycc_line_ram
// single-port line buffer of even-row chroma, registered read
// ----------------------------------------------------------------------------
module ycc_line_ram (
  input  logic                        clk,
  input  logic                        wr,
  input  logic                        rd,
  input  logic [ycc_pkg::ADDR_W-1:0]  addr,
  input  ycc_pkg::chroma_t            wdata,
  output ycc_pkg::chroma_t            rdata
);
  import ycc_pkg::*;

  chroma_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr) mem[addr] <= wdata;
    if (rd) rdata <= mem[addr];
  end

endmodule

// ===== tb/rgb_to_ycbcr_440_subsampler_test.sv =====
// ----------------------------------------------------------------------------
// rgb_to_ycbcr_440_subsampler_test
// drives rgb pixels through the converter under several frame geometries and
// luma settings, predicts every ycbcr result with fixed point arithmetic of
// its own and compares each output transfer field by field, in order
// ----------------------------------------------------------------------------

localparam longint YCC_K_R  = 19595;
localparam longint YCC_K_G  = 38470;
localparam longint YCC_K_B  = 7471;
localparam longint YCC_K_CB = 37028;
localparam longint YCC_K_CR = 46727;

typedef struct packed {
  logic signed [ycc_pkg::LUMA_W-1:0]   luma;
  logic signed [ycc_pkg::CHROMA_W-1:0] cb;
  logic signed [ycc_pkg::CHROMA_W-1:0] cr;
  logic                                cv;
} ycc_result_t;

class ycc_tracker;
  int          keep_luma;
  int          line_width;
  int          frame_height;
  int          column;
  int          row;
  longint      line_cb[ycc_pkg::MAX_WIDTH];
  longint      line_cr[ycc_pkg::MAX_WIDTH];
  ycc_result_t expected_ycc[$];
  int          pixels;
  int          outputs;
  int          averaged;
  int          flushed;
  int          errors;

  function new();
    keep_luma    = 1;
    line_width   = 2048;
    frame_height = 4096;
    column       = 0;
    row          = 0;
    pixels       = 0;
    outputs      = 0;
    averaged     = 0;
    flushed      = 0;
    errors       = 0;
  endfunction

  function void write_reg(logic [ycc_pkg::CFG_IDX_W-1:0] idx,
                          logic [ycc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      ycc_pkg::CFG_KEEP_LUMA:    keep_luma    = int'(data[0]);
      ycc_pkg::CFG_LINE_WIDTH:   line_width   = int'(data[ycc_pkg::LW_W-1:0]);
      ycc_pkg::CFG_FRAME_HEIGHT: frame_height = int'(data[ycc_pkg::FH_W-1:0]);
      default: ;
    endcase
  endfunction

  function longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -(longint'(1) << (w - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one accepted pixel: predict its result and advance the raster position
  function void convert_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    longint      rp, gp, bp, y16, yv, cbv, crv;
    longint      avg_cb, avg_cr;
    int          w, h, col;
    bit          valid;
    ycc_result_t want;
    w = (line_width == 0) ? 1 : (line_width > ycc_pkg::MAX_WIDTH) ? ycc_pkg::MAX_WIDTH
                                                                   : line_width;
    h = (frame_height == 0) ? 1 : (frame_height > ycc_pkg::MAX_ROWS) ? ycc_pkg::MAX_ROWS
                                                                      : frame_height;
    rp  = longint'(r) - 128;
    gp  = longint'(g) - 128;
    bp  = longint'(b) - 128;
    y16 = YCC_K_R * rp + YCC_K_G * gp + YCC_K_B * bp;
    // round to nearest with ties up is a floor after adding half
    yv  = clamp((y16 + (longint'(1) << (ycc_pkg::LUMA_SH - 1))) >>> ycc_pkg::LUMA_SH,
                ycc_pkg::LUMA_W);
    cbv = YCC_K_CB * ((bp <<< ycc_pkg::COEF_BITS) - y16);
    crv = YCC_K_CR * ((rp <<< ycc_pkg::COEF_BITS) - y16);
    cbv = clamp((cbv + (longint'(1) << (ycc_pkg::CHROMA_SH - 1))) >>> ycc_pkg::CHROMA_SH,
                ycc_pkg::CHROMA_W);
    crv = clamp((crv + (longint'(1) << (ycc_pkg::CHROMA_SH - 1))) >>> ycc_pkg::CHROMA_SH,
                ycc_pkg::CHROMA_W);
    col   = column % ycc_pkg::MAX_WIDTH;
    valid = 1'b0;
    want  = '0;
    if (row % 2 == 1) begin
      avg_cb  = (line_cb[col] + cbv + 1) >>> 1;
      avg_cr  = (line_cr[col] + crv + 1) >>> 1;
      want.cb = avg_cb[ycc_pkg::CHROMA_W-1:0];
      want.cr = avg_cr[ycc_pkg::CHROMA_W-1:0];
      valid   = 1'b1;
      averaged++;
    end else begin
      line_cb[col] = cbv;
      line_cr[col] = crv;
      // trailing even row goes out unaveraged
      if (row == h - 1) begin
        want.cb = cbv[ycc_pkg::CHROMA_W-1:0];
        want.cr = crv[ycc_pkg::CHROMA_W-1:0];
        valid   = 1'b1;
        flushed++;
      end
    end
    want.cv = valid;
    if (keep_luma != 0) want.luma = yv[ycc_pkg::LUMA_W-1:0];
    if (valid || keep_luma != 0) expected_ycc.push_back(want);
    pixels++;
    column++;
    if (column >= w) begin
      column = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  function void report(string field, logic signed [31:0] want, logic signed [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  function void match_output(ycc_result_t got);
    ycc_result_t want;
    outputs++;
    if (expected_ycc.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual luma %0d cb %0d cr %0d cv %0d",
               $time, got.luma, got.cb, got.cr, got.cv);
      return;
    end
    want = expected_ycc.pop_front();
    if (got.luma !== want.luma) report("luma", want.luma, got.luma);
    if (got.cb !== want.cb) report("blue_diff", want.cb, got.cb);
    if (got.cr !== want.cr) report("red_diff", want.cr, got.cr);
    if (got.cv !== want.cv) report("chroma_valid", want.cv, got.cv);
  endfunction
endclass

module rgb_to_ycbcr_440_subsampler_test;
  import ycc_pkg::*;

  localparam int RAND_PHASES  = 24;
  // columns written on an even row before any odd row; later widths stay within
  localparam int FILL_COLUMNS = 64;

  logic                        clk;
  logic                        rst       = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  logic [PIX_W-1:0]            red       = '0;
  logic [PIX_W-1:0]            green     = '0;
  logic [PIX_W-1:0]            blue      = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [LUMA_W-1:0]    luma;
  logic signed [CHROMA_W-1:0]  blue_diff;
  logic signed [CHROMA_W-1:0]  red_diff;
  logic                        chroma_valid;

  ycc_tracker tracker;
  int         send_gap_pct   = 30;
  int         recv_stall_pct = 64;

  bit [23:0] corners[9] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                            24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h808080};

  rgb_to_ycbcr_440_subsampler dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .luma         (luma),
    .blue_diff    (blue_diff),
    .red_diff     (red_diff),
    .chroma_valid (chroma_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** rgb_to_ycbcr_440_subsampler: FAILED **");
    $finish;
  end

  // output side: check each transfer, then pick the next stall
  always @(posedge clk) begin : receiver
    ycc_result_t got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{luma, blue_diff, red_diff, chroma_valid};
        tracker.match_output(got);
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic bit [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_width();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return $urandom_range(41, FILL_COLUMNS);
      4, 5:    return $urandom_range(3, 8);
      default: return $urandom_range(9, 40);
    endcase
  endfunction

  function automatic int pick_height();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 2;
      3:       return $urandom_range(0, 1) ? 4096 : 8191;
      default: return $urandom_range(3, 6);
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic push_pixel(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.convert_pixel(r, g, b);
  endtask

  // wait for every expected result, then let pixels without a result drain
  task automatic settle();
    int saved;
    saved          = recv_stall_pct;
    in_valid      <= 1'b0;
    recv_stall_pct = 0;
    while (tracker.expected_ycc.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    recv_stall_pct = saved;
  endtask

  task automatic load_config(input int keep, input int width, input int height);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_KEEP_LUMA;
    cfg_data  <= CFG_DATA_W'(keep);
    @(posedge clk);
    tracker.write_reg(CFG_KEEP_LUMA, CFG_DATA_W'(keep));
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data  <= CFG_DATA_W'(width);
    @(posedge clk);
    tracker.write_reg(CFG_LINE_WIDTH, CFG_DATA_W'(width));
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(height);
    @(posedge clk);
    tracker.write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(height));
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    int p;
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: even row, luma only
    foreach (corners[i]) push_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
    // chroma only on an even row that is not the last: nothing comes out
    load_config(0, 2048, 4096);
    for (int i = 0; i < 3; i++) push_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);

    // oversize width and zero height: every pixel flushed, and row 0 fills
    // the line buffer up to the widest column later frames can reach
    load_config(1, 4095, 0);
    n = FILL_COLUMNS - tracker.column;
    repeat (n) push_pixel(pick_level(), pick_level(), pick_level());

    // 3x3 frame: averaged odd row and trailing even row
    load_config(0, 3, 3);
    foreach (corners[i]) push_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);

    // shrink the width mid-row so the column counter wraps past the limit
    load_config(1, 8, 4);
    repeat (5) push_pixel(pick_level(), pick_level(), pick_level());
    load_config(1, 2, 4);
    repeat (3) push_pixel(pick_level(), pick_level(), pick_level());

    for (p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES / 3) begin
        send_gap_pct   = 64;
        recv_stall_pct = 30;
      end
      if (p == 2 * RAND_PHASES / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      load_config($urandom_range(0, 1), pick_width(), pick_height());
      n = $urandom_range(10, 46);
      repeat (n) push_pixel(pick_level(), pick_level(), pick_level());
    end

    settle();
    $display("%0d pixels in, %0d results checked: %0d row-pair averages, %0d flushed rows",
             tracker.pixels, tracker.outputs, tracker.averaged, tracker.flushed);
    $display("geometry covered zero, narrow and oversize widths and heights, %0d errors",
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("** rgb_to_ycbcr_440_subsampler: PASSED **");
    end else begin
      $display("** rgb_to_ycbcr_440_subsampler: FAILED **");
    end
    $finish;
  end

endmodule

// ===== rgb_to_ycbcr_440_subsampler.f =====
+incdir+sv
sv/ycc_pkg.sv
sv/ycc_raster.sv
sv/ycc_line_ram.sv
sv/rgb_to_ycbcr_440_subsampler.sv
tb/rgb_to_ycbcr_440_subsampler_test.sv
